// ===== hdl/hilbert_tile_distributor_macros.svh =====
// Assertion macros for the Hilbert tile distributor.
// Expects clk and rst_n in the scope of each use.
`ifndef HILBERT_TILE_DISTRIBUTOR_MACROS_SVH
`define HILBERT_TILE_DISTRIBUTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htd check failed");

// Consequent must hold in the cycle after the antecedent.
`define HTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htd check failed");

`endif

// ===== hdl/htd_pkg.sv =====
// Shared types and constants for the Hilbert tile distributor.
// No dependencies.
package htd_pkg;

    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int ORDER_W   = 4;
    localparam int TILE_W    = 9;
    localparam int UCNT_W    = 4;
    localparam int UNIT_W    = 3;
    localparam int COORD_OUT_W = 8;
    localparam int CMD_W     = 32;

    localparam logic [CMD_W-1:0] CMD_TILE_BASE = 32'hB800_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURVE_ORDER = 3'd0,
        REG_TILE_WIDTH  = 3'd1,
        REG_TILE_HEIGHT = 3'd2,
        REG_UNIT_COUNT  = 3'd3
    } cfg_reg_t;

    // control carried along the chain with each word
    typedef struct packed {
        logic valid;
    } stage_ctrl_t;

endpackage

// ===== hdl/htd_cell.sv =====
// One curve level of the d2xy walk, registered.
// Depends on htd_pkg.
module htd_cell #(
    parameter int LEVEL = 0,
    parameter int CW    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [htd_pkg::ORDER_W-1:0]       curve_order,
    input  htd_pkg::stage_ctrl_t              ctrl_in,
    input  logic [htd_pkg::INDEX_W-1:0]       idx_in,
    input  logic [CW-1:0]                     x_in,
    input  logic [CW-1:0]                     y_in,
    output htd_pkg::stage_ctrl_t              ctrl_out,
    output logic [htd_pkg::INDEX_W-1:0]       idx_out,
    output logic [CW-1:0]                     x_out,
    output logic [CW-1:0]                     y_out
);

    localparam logic [CW-1:0] LOW_MASK = (CW'(1) << LEVEL) - CW'(1);

    htd_pkg::stage_ctrl_t              ctrl_reg;
    logic [htd_pkg::INDEX_W-1:0]       idx_reg, idx_next;
    logic [CW-1:0]                     x_reg, x_next;
    logic [CW-1:0]                     y_reg, y_next;
    logic                              active;
    logic                              qx, qy;
    logic [CW-1:0]                     xr, yr;

    // levels at or above the configured order pass x and y through untouched
    assign active = (32'(curve_order) > LEVEL);
    assign qx     = idx_in[1];
    assign qy     = idx_in[0] ^ idx_in[1];

    always_comb
    begin
        xr = x_in;
        yr = y_in;
        if (!qy)
        begin
            if (qx)
            begin
                // reflect within the lower levels
                xr = y_in ^ LOW_MASK;
                yr = x_in ^ LOW_MASK;
            end
            else
            begin
                xr = y_in;
                yr = x_in;
            end
        end
        idx_next = idx_in >> 2;
        if (active)
        begin
            x_next = xr | (CW'(qx) << LEVEL);
            y_next = yr | (CW'(qy) << LEVEL);
        end
        else
        begin
            x_next = x_in;
            y_next = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg <= idx_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign idx_out  = idx_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;

endmodule

// ===== hdl/htd_dispatch.sv =====
// Bounds check, round-robin unit pointer and output register.
// Depends on htd_pkg.
module htd_dispatch #(
    parameter int CW        = 8,
    parameter int MAX_UNITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  htd_pkg::stage_ctrl_t              ctrl_in,
    input  logic [CW-1:0]                     x_in,
    input  logic [CW-1:0]                     y_in,
    input  logic [htd_pkg::TILE_W-1:0]        tile_width,
    input  logic [htd_pkg::TILE_W-1:0]        tile_height,
    input  logic [htd_pkg::UCNT_W-1:0]        unit_count,
    output logic                              out_valid,
    output logic                              out_inside,
    output logic [htd_pkg::COORD_OUT_W-1:0]   out_x,
    output logic [htd_pkg::COORD_OUT_W-1:0]   out_y,
    output logic [htd_pkg::UNIT_W-1:0]        out_unit,
    output logic [htd_pkg::CMD_W-1:0]         out_cmd
);

    localparam int CMPW = (CW > htd_pkg::TILE_W) ? CW : htd_pkg::TILE_W;
    localparam logic [htd_pkg::UCNT_W-1:0] UNITS_CAP = htd_pkg::UCNT_W'(MAX_UNITS);

    logic                              valid_reg;
    logic                              inside_reg, inside_next;
    logic [htd_pkg::COORD_OUT_W-1:0]   x_reg, y_reg;
    logic [htd_pkg::UNIT_W-1:0]        unit_reg, unit_next;
    logic [htd_pkg::CMD_W-1:0]         cmd_reg, cmd_next;
    logic [htd_pkg::UNIT_W-1:0]        next_unit_reg, next_unit_next;
    logic [htd_pkg::UCNT_W-1:0]        cnt_eff, cur, cur_inc;
    logic [htd_pkg::COORD_OUT_W-1:0]   x8, y8;

    assign x8 = htd_pkg::COORD_OUT_W'(x_in);
    assign y8 = htd_pkg::COORD_OUT_W'(y_in);

    always_comb
    begin
        inside_next = (CMPW'(x_in) < CMPW'(tile_width)) &&
                      (CMPW'(y_in) < CMPW'(tile_height));
        if (unit_count == '0)
            cnt_eff = htd_pkg::UCNT_W'(1);
        else if (unit_count > UNITS_CAP)
            cnt_eff = UNITS_CAP;
        else
            cnt_eff = unit_count;
        // stale pointer after the count was lowered restarts at unit 0
        cur     = (htd_pkg::UCNT_W'(next_unit_reg) < cnt_eff) ?
                  htd_pkg::UCNT_W'(next_unit_reg) : '0;
        cur_inc = cur + htd_pkg::UCNT_W'(1);
        next_unit_next = next_unit_reg;
        unit_next      = '0;
        cmd_next       = '0;
        if (inside_next)
        begin
            unit_next      = htd_pkg::UNIT_W'(cur);
            next_unit_next = (cur_inc >= cnt_eff) ? '0 : htd_pkg::UNIT_W'(cur_inc);
            cmd_next       = htd_pkg::CMD_TILE_BASE | {16'b0, y8, x8};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            next_unit_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= ctrl_in.valid;
            if (ctrl_in.valid)
                next_unit_reg <= next_unit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctrl_in.valid)
        begin
            inside_reg <= inside_next;
            x_reg      <= x8;
            y_reg      <= y8;
            unit_reg   <= unit_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_inside = inside_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_unit   = unit_reg;
    assign out_cmd    = cmd_reg;

endmodule

// ===== hdl/hilbert_tile_distributor.sv =====
// An input word passes one register per curve level in the cell chain and one for
// dispatch on its way to the output word. Throughput: one word per cycle;
// the whole chain advances whenever the output register is empty or being taken.
// Reset: asynchronous, active low; clears word valids and the unit pointer, and
// sets curve_order, tile_width, tile_height to 0 and unit_count to 1.
// Top level of the Hilbert tile distributor; uses htd_pkg, htd_cell, htd_dispatch.
`include "hilbert_tile_distributor_macros.svh"

module hilbert_tile_distributor #(
    parameter int MAX_ORDER = 8,
    parameter int MAX_UNITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [htd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [htd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] curve_index
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] tile_x, [15:8] tile_y, [18:16] unit_select, [50:19] command_word,
    // [55:51] zero
    output logic [55:0]                         m_tdata,
    output logic                                m_tuser   // [0] inside_res
);

    localparam int CW = MAX_ORDER;

    logic [htd_pkg::ORDER_W-1:0]  curve_order_reg;
    logic [htd_pkg::TILE_W-1:0]   tile_width_reg;
    logic [htd_pkg::TILE_W-1:0]   tile_height_reg;
    logic [htd_pkg::UCNT_W-1:0]   unit_count_reg;

    logic                         adv;

    htd_pkg::stage_ctrl_t         ctrl_chain [MAX_ORDER+1];
    logic [htd_pkg::INDEX_W-1:0]  idx_chain  [MAX_ORDER+1];
    logic [CW-1:0]                x_chain    [MAX_ORDER+1];
    logic [CW-1:0]                y_chain    [MAX_ORDER+1];

    logic                         d_inside;
    logic [7:0]                   d_x, d_y;
    logic [2:0]                   d_unit;
    logic [31:0]                  d_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= '0;
            tile_width_reg  <= '0;
            tile_height_reg <= '0;
            unit_count_reg  <= htd_pkg::UCNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                htd_pkg::REG_CURVE_ORDER: curve_order_reg <= htd_pkg::ORDER_W'(cfg_data);
                htd_pkg::REG_TILE_WIDTH:  tile_width_reg  <= cfg_data;
                htd_pkg::REG_TILE_HEIGHT: tile_height_reg <= cfg_data;
                htd_pkg::REG_UNIT_COUNT:  unit_count_reg  <= htd_pkg::UCNT_W'(cfg_data);
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign ctrl_chain[0].valid = s_tvalid;
    assign idx_chain[0]        = s_tdata;
    assign x_chain[0]          = '0;
    assign y_chain[0]          = '0;

    // finest level first
    for (genvar g = 0; g < MAX_ORDER; g++)
    begin : g_cell
        htd_cell #(
            .LEVEL (g),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (adv),
            .curve_order (curve_order_reg),
            .ctrl_in     (ctrl_chain[g]),
            .idx_in      (idx_chain[g]),
            .x_in        (x_chain[g]),
            .y_in        (y_chain[g]),
            .ctrl_out    (ctrl_chain[g+1]),
            .idx_out     (idx_chain[g+1]),
            .x_out       (x_chain[g+1]),
            .y_out       (y_chain[g+1])
        );
    end

    htd_dispatch #(
        .CW        (CW),
        .MAX_UNITS (MAX_UNITS)
    ) u_dispatch (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .ctrl_in     (ctrl_chain[MAX_ORDER]),
        .x_in        (x_chain[MAX_ORDER]),
        .y_in        (y_chain[MAX_ORDER]),
        .tile_width  (tile_width_reg),
        .tile_height (tile_height_reg),
        .unit_count  (unit_count_reg),
        .out_valid   (m_tvalid),
        .out_inside  (d_inside),
        .out_x       (d_x),
        .out_y       (d_y),
        .out_unit    (d_unit),
        .out_cmd     (d_cmd)
    );

    assign m_tdata = {5'b0, d_cmd, d_unit, d_y, d_x};
    assign m_tuser = d_inside;

    `HTD_ASSERT_SAME(a_outside_zero, m_tvalid && !m_tuser, m_tdata[50:16] == '0)
    `HTD_ASSERT_SAME(a_cmd_coords, m_tvalid && m_tuser, m_tdata[34:19] == m_tdata[15:0])
    `HTD_ASSERT_SAME(a_cmd_base, m_tvalid && m_tuser,
                     m_tdata[50:35] == htd_pkg::CMD_TILE_BASE[31:16])
    `HTD_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

endmodule
